### src/dwgs_pkg.sv
// Shared types, constants and helper functions of the damped wave grid stepper.
package dwgs_pkg;

    localparam int GRID_DIM  = 64;
    localparam int COORD_W   = $clog2(GRID_DIM);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int DEPTH     = GRID_DIM * GRID_DIM;
    localparam int H_W       = 20;
    localparam int CFG_W     = 16;
    localparam int SPLASH_R  = 3;
    localparam int RAIN_R    = 2;

    localparam logic signed [27:0] HMAX = 28'sd524287;
    localparam logic signed [27:0] HMIN = -28'sd524288;

    localparam logic [1:0] CFG_COEFF   = 2'd0;
    localparam logic [1:0] CFG_DAMPING = 2'd1;
    localparam logic [1:0] CFG_LAST    = 2'd2;

    localparam logic [CFG_W-1:0]   COEFF_RST   = 16'd16384;
    localparam logic [CFG_W-1:0]   DAMPING_RST = 16'd64881;
    localparam logic [COORD_W-1:0] LAST_RST    = 6'd63;

    // exp(-d*d/8) and exp(-d*d/1.5) in Q0.16, unity stored as 65536
    localparam logic [16:0] SPLASH_TAB [8] = '{17'd65536, 17'd57835, 17'd39750, 17'd21276,
                                               17'd8869, 17'd2879, 17'd728, 17'd143};
    localparam logic [16:0] RAIN_TAB [8]   = '{17'd65536, 17'd33647, 17'd4554, 17'd162,
                                               17'd2, 17'd0, 17'd0, 17'd0};

    typedef logic signed [H_W-1:0] height_t;

    typedef enum logic [1:0] {
        MODE_STEP   = 2'd0,
        MODE_SPLASH = 2'd1,
        MODE_RAIN   = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                mode;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        height_t              amount;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0]   wave_coeff;
        logic [CFG_W-1:0]   damping;
        logic [COORD_W-1:0] grid_last;
    } cfg_t;

    typedef struct packed {
        logic clearing;
    } eng_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_SPLASH,
        ST_READ,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        height_t h;
        logic    sat;
    } clip_t;

    function automatic clip_t clip_h(input logic signed [27:0] v);
        clip_t r;
        if (v > HMAX) begin
            r.h   = height_t'(HMAX);
            r.sat = 1'b1;
        end else if (v < HMIN) begin
            r.h   = height_t'(HMIN);
            r.sat = 1'b1;
        end else begin
            r.h   = v[H_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [16:0] tab_w(input logic rain, input logic [2:0] i);
        return rain ? RAIN_TAB[i] : SPLASH_TAB[i];
    endfunction

endpackage

### src/dwgs_front.sv
// Input side: unpacks stream transactions into commands and queues them.
module dwgs_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    input  dwgs_pkg::eng_stat_t stat,
    output logic               q_valid,
    input  logic               q_ready,
    output dwgs_pkg::cmd_t     q_cmd
);
    import dwgs_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       in_cmd;
    logic       push, pop;

    always_comb begin
        in_cmd.mode   = mode_t'(s_tuser);
        in_cmd.col    = s_tdata[5:0];
        in_cmd.row    = s_tdata[11:6];
        in_cmd.amount = s_tdata[31:12];
    end

    assign s_tready = (count_reg != 2'd2) && !stat.clearing;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### src/dwgs_engine.sv
// Back end: grid memories, step/splash/read sequencer and result register.
module dwgs_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  dwgs_pkg::cfg_t      cfg,
    input  logic                q_valid,
    output logic                q_ready,
    input  dwgs_pkg::cmd_t      q_cmd,
    output dwgs_pkg::eng_stat_t stat,
    output logic                m_valid,
    input  logic                m_ready,
    output dwgs_pkg::height_t   m_height,
    output logic                m_sat
);
    import dwgs_pkg::*;

    height_t mem_a [DEPTH];
    height_t mem_b [DEPTH];
    height_t a_rdata_reg, b_rdata_reg;

    eng_state_t state_reg, state_next;
    logic       cur_b_reg;
    cmd_t       cmd_reg;
    logic [2:0] ph_reg;
    logic [COORD_W-1:0] zi_reg, xi_reg;
    logic signed [3:0]  dz_reg, dx_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic               sat_reg;
    logic signed [21:0] acc_reg;
    logic signed [41:0] t_reg;
    logic signed [39:0] pa_reg;
    logic [34:0]        pb_reg;
    logic [16:0]        w_reg;
    logic signed [21:0] push_reg;
    height_t            cen_reg;
    logic [ADDR_W-1:0]  tgt_reg;
    height_t            res_h_reg;
    logic               out_valid_reg;
    height_t            out_h_reg;
    logic               out_sat_reg;

    // datapath
    height_t            cur_rdata, prev_rdata;
    logic [COORD_W-1:0] last, lastm1;
    logic               small_grid, step_end, row_end;
    logic signed [22:0] lap;
    logic signed [21:0] base2;
    logic signed [39:0] prod_c;
    logic signed [41:0] t_next;
    logic signed [59:0] psum;
    clip_t              step_clip, splash_clip;
    logic               rain;
    logic signed [3:0]  rad;
    logic signed [7:0]  xs, zs, limit;
    logic               tgt_ok, splash_end;
    logic [2:0]         ax, az;
    logic [33:0]        wprod;
    logic signed [37:0] aprod;
    logic signed [27:0] ssum;
    logic               read_ok, out_free;

    // memory control
    logic [ADDR_W-1:0] cur_raddr, prev_raddr, wr_addr;
    height_t           wr_data;
    logic              cur_we, prev_we, clr_we;
    logic [ADDR_W-1:0] a_raddr, b_raddr, a_waddr, b_waddr;
    logic              a_we, b_we;
    height_t           a_wdata, b_wdata;

    assign cur_rdata  = cur_b_reg ? b_rdata_reg : a_rdata_reg;
    assign prev_rdata = cur_b_reg ? a_rdata_reg : b_rdata_reg;
    assign last       = cfg.grid_last;
    assign lastm1     = last - 6'd1;
    assign small_grid = (last < 6'd2);
    assign row_end    = (xi_reg == lastm1);
    assign step_end   = row_end && (zi_reg == lastm1);
    assign out_free   = !out_valid_reg || m_ready;

    always_comb begin
        lap    = {acc_reg[21], acc_reg} - {cur_rdata[H_W-1], cur_rdata, 2'b00};
        base2  = {cur_rdata[H_W-1], cur_rdata, 1'b0} - {{2{prev_rdata[H_W-1]}}, prev_rdata};
        prod_c = $signed({1'b0, cfg.wave_coeff}) * lap;
        t_next = {{4{base2[21]}}, base2, 16'h0000} + {{2{prod_c[39]}}, prod_c};
        psum   = {pa_reg[39], pa_reg, 19'd0} + {25'd0, pb_reg} + 60'sh0_8000_0000;
        step_clip = clip_h(psum[59:32]);
    end

    always_comb begin
        rain  = (cmd_reg.mode == MODE_RAIN);
        rad   = rain ? 4'(RAIN_R) : 4'(SPLASH_R);
        xs    = $signed({2'b00, cmd_reg.col}) + 8'(dx_reg);
        zs    = $signed({2'b00, cmd_reg.row}) + 8'(dz_reg);
        limit = $signed({2'b00, last}) - (rain ? 8'sd1 : 8'sd0);
        tgt_ok = (xs > 8'sd0) && (xs < limit) && (zs > 8'sd0) && (zs < limit);
        splash_end = (dx_reg == rad) && (dz_reg == rad);
        ax    = dx_reg[3] ? 3'(-dx_reg) : dx_reg[2:0];
        az    = dz_reg[3] ? 3'(-dz_reg) : dz_reg[2:0];
        wprod = tab_w(rain, ax) * tab_w(rain, az) + 34'd32768;
        aprod = cmd_reg.amount * $signed({1'b0, w_reg}) + 38'sd32768;
        ssum  = 28'(cen_reg) + 28'(push_reg);
        splash_clip = clip_h(ssum);
        read_ok = (cmd_reg.col <= last) && (cmd_reg.row <= last);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.mode)
                        MODE_STEP:   state_next = ST_STEP;
                        MODE_SPLASH: state_next = ST_SPLASH;
                        MODE_RAIN:   state_next = ST_SPLASH;
                        default:     state_next = ST_READ;
                    endcase
                end
            end
            ST_STEP: begin
                if ((ph_reg == 3'd0 && small_grid) || (ph_reg == 3'd7 && step_end))
                    state_next = ST_DONE;
            end
            ST_SPLASH: begin
                if (splash_end && ((ph_reg == 3'd0 && !tgt_ok) || ph_reg == 3'd2))
                    state_next = ST_DONE;
            end
            ST_READ: begin
                if (ph_reg == 3'd1) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // memory and handshake control
    always_comb begin
        q_ready    = (state_reg == ST_IDLE);
        cur_raddr  = {cmd_reg.row, cmd_reg.col};
        prev_raddr = {zi_reg, xi_reg};
        wr_addr    = tgt_reg;
        wr_data    = splash_clip.h;
        cur_we     = 1'b0;
        prev_we    = 1'b0;
        clr_we     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                clr_we  = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            ST_STEP: begin
                case (ph_reg)
                    3'd0:    cur_raddr = {zi_reg, xi_reg - 6'd1};
                    3'd1:    cur_raddr = {zi_reg, xi_reg + 6'd1};
                    3'd2:    cur_raddr = {zi_reg - 6'd1, xi_reg};
                    3'd3:    cur_raddr = {zi_reg + 6'd1, xi_reg};
                    3'd4:    cur_raddr = {zi_reg, xi_reg};
                    default: cur_raddr = {zi_reg, xi_reg};
                endcase
                if (ph_reg == 3'd7) begin
                    prev_we = 1'b1;
                    wr_addr = {zi_reg, xi_reg};
                    wr_data = step_clip.h;
                end
            end
            ST_SPLASH: begin
                cur_raddr = {zs[COORD_W-1:0], xs[COORD_W-1:0]};
                if (ph_reg == 3'd2) cur_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        a_raddr = cur_b_reg ? prev_raddr : cur_raddr;
        b_raddr = cur_b_reg ? cur_raddr : prev_raddr;
        a_we    = clr_we || (cur_b_reg ? prev_we : cur_we);
        b_we    = clr_we || (cur_b_reg ? cur_we : prev_we);
        a_waddr = wr_addr;
        b_waddr = wr_addr;
        a_wdata = wr_data;
        b_wdata = wr_data;
    end

    always_ff @(posedge aclk) begin
        if (a_we) mem_a[a_waddr] <= a_wdata;
        a_rdata_reg <= mem_a[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) mem_b[b_waddr] <= b_wdata;
        b_rdata_reg <= mem_b[b_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cur_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            ph_reg        <= 3'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == ST_DONE && out_free) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: ph_reg <= 3'd0;
                ST_STEP: begin
                    ph_reg <= ph_reg + 3'd1;
                    if ((ph_reg == 3'd0 && small_grid) || (ph_reg == 3'd7 && step_end))
                        cur_b_reg <= ~cur_b_reg;
                end
                ST_SPLASH: begin
                    if (ph_reg == 3'd0 && tgt_ok) ph_reg <= 3'd1;
                    else if (ph_reg == 3'd1) ph_reg <= 3'd2;
                    else ph_reg <= 3'd0;
                end
                ST_READ: ph_reg <= ph_reg + 3'd1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cmd_reg   <= q_cmd;
                sat_reg   <= 1'b0;
                res_h_reg <= '0;
                zi_reg    <= 6'd1;
                xi_reg    <= 6'd1;
                dz_reg    <= (q_cmd.mode == MODE_RAIN) ? -4'(RAIN_R) : -4'(SPLASH_R);
                dx_reg    <= (q_cmd.mode == MODE_RAIN) ? -4'(RAIN_R) : -4'(SPLASH_R);
            end
            ST_STEP: begin
                case (ph_reg)
                    3'd1: acc_reg <= 22'(cur_rdata);
                    3'd2: acc_reg <= acc_reg + 22'(cur_rdata);
                    3'd3: acc_reg <= acc_reg + 22'(cur_rdata);
                    3'd4: acc_reg <= acc_reg + 22'(cur_rdata);
                    3'd5: t_reg   <= t_next;
                    3'd6: begin
                        pa_reg <= $signed(t_reg[41:19]) * $signed({1'b0, cfg.damping});
                        pb_reg <= t_reg[18:0] * cfg.damping;
                    end
                    3'd7: begin
                        sat_reg <= sat_reg | step_clip.sat;
                        // advance to the next interior point
                        if (row_end) begin
                            xi_reg <= 6'd1;
                            zi_reg <= zi_reg + 6'd1;
                        end else begin
                            xi_reg <= xi_reg + 6'd1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SPLASH: begin
                if (ph_reg == 3'd0) begin
                    w_reg   <= wprod[32:16];
                    tgt_reg <= {zs[COORD_W-1:0], xs[COORD_W-1:0]};
                end
                if (ph_reg == 3'd1) begin
                    cen_reg  <= cur_rdata;
                    push_reg <= aprod[37:16];
                end
                if (ph_reg == 3'd2) sat_reg <= sat_reg | splash_clip.sat;
                if ((ph_reg == 3'd0 && !tgt_ok) || ph_reg == 3'd2) begin
                    if (dx_reg == rad) begin
                        dx_reg <= -rad;
                        dz_reg <= dz_reg + 4'sd1;
                    end else begin
                        dx_reg <= dx_reg + 4'sd1;
                    end
                end
            end
            ST_READ: begin
                if (ph_reg == 3'd1) res_h_reg <= read_ok ? cur_rdata : '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_h_reg   <= res_h_reg;
                    out_sat_reg <= sat_reg;
                end
            end
            default: ;
        endcase
    end

    assign stat.clearing = (state_reg == ST_CLEAR);
    assign m_valid  = out_valid_reg;
    assign m_height = out_h_reg;
    assign m_sat    = out_sat_reg;

endmodule

### src/damped_wave_grid_stepper.sv
// Top level: configuration registers, command queue and wave engine.
//
// Usage: each input transaction carries one command in s_tuser (0 step,
// 1 splash, 2 rain splash, 3 read) with col, row and amount in s_tdata.
// Every command yields exactly one result transaction on the m_ side:
// the height in m_tdata (nonzero only for a read) and the saturation flag
// in m_tuser. Configuration registers are written through cfg_wr_en,
// cfg_index and cfg_wdata, one write per cycle; the user must write
// them only while the block is idle, and the block does not enforce it.
// Work: a step visits every interior point in turn, paced by the single
// read port of the current grid (five reads per point) and the two
// multiply stages. A splash visits 49 or 25 targets and updates those
// inside the grid. One command is worked at a time; a two-entry queue
// takes the next commands meanwhile.
// Reset: both grids are swept to zero, one address per cycle;
// s_tready stays low until the sweep ends.
// When m_tready is low the result is held and the engine waits with the
// next finished result.
module damped_wave_grid_stepper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // col[5:0], row[11:6], amount[31:12]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // height[19:0], zero fill[23:20]
    output logic        m_tuser,   // saturated
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import dwgs_pkg::*;

    cfg_t      cfg_reg;
    eng_stat_t stat;
    logic      q_valid, q_ready;
    cmd_t      q_cmd;
    height_t   m_height;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wave_coeff <= COEFF_RST;
            cfg_reg.damping    <= DAMPING_RST;
            cfg_reg.grid_last  <= LAST_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COEFF:   cfg_reg.wave_coeff <= cfg_wdata;
                CFG_DAMPING: cfg_reg.damping    <= cfg_wdata;
                CFG_LAST:    cfg_reg.grid_last  <= cfg_wdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    dwgs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    dwgs_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .stat     (stat),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_height (m_height),
        .m_sat    (m_tuser)
    );

    assign m_tdata = {4'b0000, m_height};

`ifndef SYNTHESIS
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.clearing |-> !s_tready) else $error("input taken during clear sweep");
    a_no_result_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.clearing |-> !m_tvalid) else $error("result during clear sweep");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |=> !q_ready) else $error("engine took two commands");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for damped_wave_grid_stepper: grid predictor, driver and monitor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dwgs_pkg::*;

    localparam int LIMIT = 3000000;

    typedef struct {
        logic [23:0] data;
        logic        sat;
    } wave_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    damped_wave_grid_stepper dut (.*);

    // model state
    int           heights [2][DEPTH];
    bit           cur_sel;
    int unsigned  coeff_q16, damp_q16, last_idx;
    bit           sat_seen;

    cmd_t         cmd_queue [$];
    cmd_t         in_flight;
    wave_result_t result_queue [$];
    int           send_idle_pct, recv_stall_pct;
    int           fails, n_sent, n_recv, n_steps, n_sat;
    int           cycles;

    initial begin
        aclk = 1'b0;
    end
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int clip_height(longint v);
        if (v > 524287) begin
            sat_seen = 1'b1;
            return 524287;
        end
        if (v < -524288) begin
            sat_seen = 1'b1;
            return -524288;
        end
        return int'(v);
    endfunction

    function automatic void wave_step();
        int     i;
        longint c, lap, t, r;
        for (int z = 1; z < int'(last_idx); z++) begin
            for (int x = 1; x < int'(last_idx); x++) begin
                i   = z * GRID_DIM + x;
                c   = heights[cur_sel][i];
                lap = longint'(heights[cur_sel][i-1]) + heights[cur_sel][i+1]
                    + heights[cur_sel][i-GRID_DIM] + heights[cur_sel][i+GRID_DIM] - 4 * c;
                t   = (2 * c - heights[!cur_sel][i]) * 65536 + longint'(coeff_q16) * lap;
                r   = (t * longint'(damp_q16) + (longint'(1) << 31)) >>> 32;
                heights[!cur_sel][i] = clip_height(r);
            end
        end
        cur_sel = !cur_sel;
    endfunction

    function automatic void add_splash(int cx, int cz, longint amt, bit rain);
        int     rad, lim, x, z, ax, az;
        longint w, push;
        rad = rain ? RAIN_R : SPLASH_R;
        lim = rain ? int'(last_idx) - 1 : int'(last_idx);
        for (int dz = -rad; dz <= rad; dz++) begin
            for (int dx = -rad; dx <= rad; dx++) begin
                x = cx + dx;
                z = cz + dz;
                if (x > 0 && x < lim && z > 0 && z < lim) begin
                    ax   = dx < 0 ? -dx : dx;
                    az   = dz < 0 ? -dz : dz;
                    w    = rain ? (longint'(RAIN_TAB[ax]) * RAIN_TAB[az] + 32768) >> 16
                                : (longint'(SPLASH_TAB[ax]) * SPLASH_TAB[az] + 32768) >> 16;
                    push = (amt * w + 32768) >>> 16;
                    heights[cur_sel][z*GRID_DIM+x] =
                        clip_height(longint'(heights[cur_sel][z*GRID_DIM+x]) + push);
                end
            end
        end
    endfunction

    function automatic wave_result_t predict_result(cmd_t c);
        wave_result_t res;
        int           h;
        h        = 0;
        sat_seen = 1'b0;
        case (c.mode)
            MODE_STEP: begin
                wave_step();
                n_steps++;
            end
            MODE_SPLASH: add_splash(c.col, c.row, longint'(c.amount), 1'b0);
            MODE_RAIN:   add_splash(c.col, c.row, longint'(c.amount), 1'b1);
            default: begin
                if (c.col <= last_idx && c.row <= last_idx)
                    h = heights[cur_sel][c.row*GRID_DIM+c.col];
            end
        endcase
        res.data = {4'b0, h[19:0]};
        res.sat  = sat_seen;
        if (sat_seen)
            n_sat++;
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_queue.push_back(predict_result(in_flight));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_flight = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {in_flight.amount, in_flight.row, in_flight.col};
                    s_tuser  <= in_flight.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        wave_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_recv++;
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result data=%h sat=%b", $time, m_tdata, m_tuser);
                    fails++;
                end else begin
                    want = result_queue.pop_front();
                    if (m_tdata !== want.data) begin
                        $display("%0t: height mismatch expected %h actual %h",
                                 $time, want.data, m_tdata);
                        fails++;
                    end
                    if (m_tuser !== want.sat) begin
                        $display("%0t: saturated mismatch expected %b actual %b",
                                 $time, want.sat, m_tuser);
                        fails++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("damped_wave_grid_stepper test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_COEFF:   coeff_q16 = val;
            CFG_DAMPING: damp_q16  = val;
            CFG_LAST:    last_idx  = val[5:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned cf, int unsigned dp, int unsigned lst);
        write_reg(CFG_COEFF, cf[15:0]);
        write_reg(CFG_DAMPING, dp[15:0]);
        write_reg(CFG_LAST, lst[15:0]);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (cmd_queue.size() > 0 || s_tvalid || result_queue.size() > 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic queue_cmd(mode_t m, int c, int r, int a);
        cmd_t k;
        k.mode   = m;
        k.col    = c[5:0];
        k.row    = r[5:0];
        k.amount = a[19:0];
        cmd_queue.push_back(k);
    endtask

    // mostly splashes and reads around the live region, a few steps
    task automatic queue_random(int n, int step_pct);
        int    lim, sel, a;
        mode_t m;
        for (int i = 0; i < n; i++) begin
            lim = int'(last_idx) + 2;
            sel = $urandom_range(0, 99);
            if (sel < step_pct)      m = MODE_STEP;
            else if (sel < 45)       m = MODE_SPLASH;
            else if (sel < 65)       m = MODE_RAIN;
            else                     m = MODE_READ;
            case ($urandom_range(0, 3))
                0:       a = $urandom;
                1:       a = $urandom_range(0, 4000) - 2000;
                default: a = $urandom_range(0, 200000) - 100000;
            endcase
            if ($urandom_range(0, 9) == 0)
                queue_cmd(m, $urandom_range(0, 63), $urandom_range(0, 63), a);
            else
                queue_cmd(m, $urandom_range(0, lim > 63 ? 63 : lim),
                          $urandom_range(0, lim > 63 ? 63 : lim), a);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cur_sel   = 1'b0;
        coeff_q16 = COEFF_RST;
        damp_q16  = DAMPING_RST;
        last_idx  = LAST_RST;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corners, every mode, edge skips, saturation
        queue_cmd(MODE_READ, 0, 0, 0);
        queue_cmd(MODE_READ, 63, 63, 0);
        queue_cmd(MODE_SPLASH, 32, 32, 524287);
        queue_cmd(MODE_SPLASH, 32, 32, 524287);
        queue_cmd(MODE_READ, 32, 32, 0);
        queue_cmd(MODE_RAIN, 10, 10, -524288);
        queue_cmd(MODE_RAIN, 10, 10, -524288);
        queue_cmd(MODE_READ, 10, 11, 0);
        queue_cmd(MODE_SPLASH, 1, 1, 100000);
        queue_cmd(MODE_SPLASH, 62, 62, -100000);
        queue_cmd(MODE_RAIN, 61, 61, 70000);
        queue_cmd(MODE_RAIN, 0, 63, 70000);
        queue_cmd(MODE_READ, 62, 62, 0);
        queue_cmd(MODE_READ, 61, 61, 0);
        queue_cmd(MODE_STEP, 0, 0, 0);
        queue_cmd(MODE_READ, 33, 32, 0);
        queue_cmd(MODE_STEP, 63, 63, -1);
        queue_cmd(MODE_READ, 32, 32, 0);
        queue_cmd(MODE_READ, 63, 0, 0);
        drain();

        for (int p = 1; p <= 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            case (p)
                1: set_config(65535, 65535, 5);
                2: set_config(0, 0, 3);
                3: set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 2));
                4: set_config(16384, 64881, 8);
                5: set_config($urandom_range(0, 65535), 65535, 63);
                6: set_config(65535, $urandom_range(50000, 65535), 4);
                7: set_config($urandom_range(0, 65535), $urandom_range(0, 65535), 12);
                default: set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                                    $urandom_range(3, 10));
            endcase
            queue_random(p == 5 ? 10 : 18, p == 5 ? 4 : 30);
            drain();
        end

        $display("Ran %0d commands with %0d steps, %0d saturating, across grid sizes",
                 n_sent, n_steps, n_sat);
        $display("and wave settings from zero to full scale under varied flow control.");
        if (fails == 0) begin
            $display("damped_wave_grid_stepper test passed");
        end else begin
            $display("damped_wave_grid_stepper test failed");
        end
        $finish;
    end
endmodule

### damped_wave_grid_stepper.f
src/dwgs_pkg.sv
src/dwgs_front.sv
src/dwgs_engine.sv
src/damped_wave_grid_stepper.sv
tb/tb.sv
